// ===== design/assert_macros.svh =====
// shared assertion macros for the stack design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent, outside of reset
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/lsd_pkg.sv =====
package lsd_pkg;

    localparam int OPC_W  = 3;
    localparam int DATA_W = 32;
    localparam int DEPTH_NOW_W = 5;

    // opcodes of an input beat
    localparam logic [OPC_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPC_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPC_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OPC_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

    // per-cell update modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] CM_HOLD       = 3'd0;
    localparam logic [MODE_W-1:0] CM_LOAD_ABOVE = 3'd1;
    localparam logic [MODE_W-1:0] CM_LOAD_BELOW = 3'd2;
    localparam logic [MODE_W-1:0] CM_COMPACT    = 3'd3;
    localparam logic [MODE_W-1:0] CM_CLEAR      = 3'd4;

    typedef logic signed [DATA_W-1:0] t_data;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_data             key;
    } t_cell_ctrl;

endpackage

// ===== design/lsd_in_if.sv =====
interface lsd_in_if import lsd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    t_data            operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

// ===== design/lsd_out_if.sv =====
interface lsd_out_if import lsd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_data                  top_value;
    logic                   empty_flag;
    logic [DEPTH_NOW_W-1:0] depth_now;
    logic                   found_flag;
    logic                   rejected_flag;

    modport source (output valid, output top_value, output empty_flag, output depth_now,
                    output found_flag, output rejected_flag, input ready);
    modport sink   (input valid, input top_value, input empty_flag, input depth_now,
                    input found_flag, input rejected_flag, output ready);
endinterface

// ===== design/lsd_cell.sv =====
module lsd_cell import lsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_above_data,
    input  logic       i_above_occ,
    input  t_data      i_below_data,
    input  logic       i_below_occ,
    input  logic       i_hit,
    output t_data      o_data,
    output logic       o_occ,
    output logic       o_hit
);

    t_data r_data;
    t_data n_data;
    logic  r_occ;
    logic  n_occ;

    // match chain: a hit at this cell or anywhere nearer the top
    assign o_hit  = i_hit | (r_occ && (r_data == i_ctrl.key));
    assign o_data = r_data;
    assign o_occ  = r_occ;

    // next entry by mode
    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        case (i_ctrl.mode)
            CM_HOLD: begin
            end
            CM_LOAD_ABOVE: begin
                n_data = i_above_data;
                n_occ  = i_above_occ;
            end
            CM_LOAD_BELOW: begin
                n_data = i_below_data;
                n_occ  = i_below_occ;
            end
            CM_COMPACT: begin
                if (o_hit) begin
                    n_data = i_below_data;
                    n_occ  = i_below_occ;
                end
            end
            CM_CLEAR: begin
                n_occ = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== design/lifo_stack_with_value_delete_unit.sv =====
// Bounded LIFO stack of DEPTH signed 32-bit entries built as a row of cells, cell 0 holding
// the top. Push, pop, search, clear and unused opcodes finish in the cycle their beat is
// accepted, so these run at one beat per cycle while the output is free. Delete removes one
// matching entry per cycle by closing the gap nearest the top; once no match is left, it
// posts its result as soon as the output is free. Each input beat gives one output beat;
// a waiting result holds off the input, and the next beat is accepted in the same cycle
// that the waiting result is taken.
`include "assert_macros.svh"

module lifo_stack_with_value_delete_unit import lsd_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsd_in_if.sink     i_in,
    lsd_out_if.source  o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DEL  = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_data            r_key;
    logic             r_del_found;

    logic             r_out_valid;
    t_data            r_top;
    logic             r_empty;
    logic [CNT_W-1:0] r_out_count;
    logic             r_found;
    logic             r_rejected;

    t_cell_ctrl       w_ctrl;
    t_data            w_data [DEPTH];
    logic [DEPTH-1:0] w_occ;
    logic [DEPTH:0]   w_hit;

    logic             w_out_free;
    logic             w_accept;
    logic             w_full;
    logic             w_any_hit;
    logic             w_load_out;
    t_data            w_top;
    logic [CNT_W-1:0] w_count;
    logic             w_found;
    logic             w_rejected;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = w_occ[DEPTH-1];
    assign w_any_hit  = w_hit[DEPTH];
    assign w_hit[0]   = 1'b0;

    // row of cells, top at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_above_data;
        logic  w_above_occ;
        t_data w_below_data;
        logic  w_below_occ;

        if (g == 0) begin : g_top
            assign w_above_data = w_ctrl.key;
            assign w_above_occ  = 1'b1;
        end else begin : g_mid
            assign w_above_data = w_data[g-1];
            assign w_above_occ  = w_occ[g-1];
        end

        if (g == DEPTH - 1) begin : g_bot
            assign w_below_data = '0;
            assign w_below_occ  = 1'b0;
        end else begin : g_up
            assign w_below_data = w_data[g+1];
            assign w_below_occ  = w_occ[g+1];
        end

        lsd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_above_data (w_above_data),
            .i_above_occ  (w_above_occ),
            .i_below_data (w_below_data),
            .i_below_occ  (w_below_occ),
            .i_hit        (w_hit[g]),
            .o_data       (w_data[g]),
            .o_occ        (w_occ[g]),
            .o_hit        (w_hit[g+1])
        );
    end

    // sequencer: cell mode, next count and the result of an op that finishes when accepted
    always_comb begin
        w_ctrl.key  = (r_state == S_IDLE) ? i_in.operand_value : r_key;
        w_ctrl.mode = CM_HOLD;
        n_state     = r_state;
        n_count     = r_count;
        w_load_out  = 1'b0;
        w_top       = w_occ[0] ? w_data[0] : '0;
        w_count     = r_count;
        w_found     = 1'b0;
        w_rejected  = 1'b0;

        if (r_state == S_IDLE) begin
            if (w_accept) begin
                w_load_out = 1'b1;
                case (i_in.opcode)
                    OP_PUSH: begin
                        if (w_full) begin
                            w_rejected = 1'b1;
                        end else begin
                            w_ctrl.mode = CM_LOAD_ABOVE;
                            n_count     = r_count + 1'b1;
                            w_top       = i_in.operand_value;
                        end
                    end
                    OP_POP: begin
                        if (w_occ[0]) begin
                            w_ctrl.mode = CM_LOAD_BELOW;
                            n_count     = r_count - 1'b1;
                            w_top       = w_occ[1] ? w_data[1] : '0;
                        end
                    end
                    OP_SEARCH: begin
                        w_found = w_any_hit;
                    end
                    OP_DELETE: begin
                        w_load_out = 1'b0;
                        n_state    = S_DEL;
                    end
                    OP_CLEAR: begin
                        w_ctrl.mode = CM_CLEAR;
                        n_count     = '0;
                        w_top       = '0;
                    end
                    default: begin
                    end
                endcase
                w_count = n_count;
            end
        end else begin
            // one removal per cycle until no match is left
            w_found = r_del_found;
            if (w_any_hit) begin
                w_ctrl.mode = CM_COMPACT;
                n_count     = r_count - 1'b1;
            end else if (w_out_free) begin
                w_load_out = 1'b1;
                n_state    = S_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // delete key, found mark and output beat payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key       <= i_in.operand_value;
            r_del_found <= 1'b0;
        end else if (r_state == S_DEL && w_any_hit) begin
            r_del_found <= 1'b1;
        end
        if (w_load_out) begin
            r_top       <= w_top;
            r_empty     <= (w_count == '0);
            r_out_count <= w_count;
            r_found     <= w_found;
            r_rejected  <= w_rejected;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.top_value     = r_top;
    assign o_out.empty_flag    = r_empty;
    assign o_out.depth_now     = DEPTH_NOW_W'(r_out_count);
    assign o_out.found_flag    = r_found;
    assign o_out.rejected_flag = r_rejected;

    // occupancy matches the count and stays packed toward the top
    `ASSERT_CLK(a_occ_count, $countones(w_occ) == 32'(r_count), "occupancy disagrees with count")
    `ASSERT_CLK(a_occ_packed, ((w_occ >> 1) & ~w_occ) == '0, "hole in occupied cells")
    `ASSERT_CLK(a_no_accept_in_del, !(r_state == S_DEL && i_in.ready), "input ready during delete")
    `ASSERT_NEXT(a_del_step, r_state == S_DEL && w_any_hit,
        r_count == $past(r_count) - 1'b1 && r_state == S_DEL, "delete step lost an entry")
    `ASSERT_NEXT(a_out_held, r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_top) && $stable(r_out_count), "waiting result overwritten")

endmodule

// ===== verif/lsd_checker.sv =====
// watches both channels, tracks the stack contents and checks every result beat
module lsd_checker import lsd_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lsd_in_if    i_in_mon,
    lsd_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_data                  top_value;
        logic                   empty_flag;
        logic [DEPTH_NOW_W-1:0] depth_now;
        logic                   found_flag;
        logic                   rejected_flag;
    } t_stack_status;

    // shadow copy of the stack, entry 0 is the bottom
    t_data         stack_mem [DEPTH];
    int unsigned   stack_cnt;
    t_stack_status status_q [$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    // apply one operation to the shadow stack and return the status it leaves
    function automatic t_stack_status stack_apply(input logic [OPC_W-1:0] opc, input t_data val);
        t_stack_status r;
        int unsigned   keep;
        r.found_flag    = 1'b0;
        r.rejected_flag = 1'b0;
        case (opc)
            OP_PUSH: begin
                if (stack_cnt >= DEPTH) begin
                    r.rejected_flag = 1'b1;
                end else begin
                    stack_mem[stack_cnt] = val;
                    stack_cnt++;
                end
            end
            OP_POP: begin
                if (stack_cnt > 0) stack_cnt--;
            end
            OP_SEARCH: begin
                for (int i = 0; i < stack_cnt; i++)
                    if (stack_mem[i] == val) r.found_flag = 1'b1;
            end
            // squeeze out every match, keeping the order of the rest
            OP_DELETE: begin
                keep = 0;
                for (int i = 0; i < stack_cnt; i++) begin
                    if (stack_mem[i] == val) begin
                        r.found_flag = 1'b1;
                    end else begin
                        stack_mem[keep] = stack_mem[i];
                        keep++;
                    end
                end
                stack_cnt = keep;
            end
            OP_CLEAR: begin
                stack_cnt = 0;
            end
            default: ;
        endcase
        r.top_value  = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
        r.empty_flag = (stack_cnt == 0);
        r.depth_now  = stack_cnt[DEPTH_NOW_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        fail_count++;
    endtask

    // predict on each input beat, compare on each output beat
    always @(posedge i_clk) begin
        t_stack_status want;
        if (!i_rst_n) begin
            stack_cnt = 0;
            status_q.delete();
        end else begin
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1)
                status_q.push_back(stack_apply(i_in_mon.opcode, i_in_mon.operand_value));
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", '0,
                                    i_out_mon.top_value);
                end else begin
                    want = status_q.pop_front();
                    if (i_out_mon.top_value !== want.top_value)
                        report_mismatch("top_value", want.top_value, i_out_mon.top_value);
                    if (i_out_mon.empty_flag !== want.empty_flag)
                        report_mismatch("empty_flag", DATA_W'(want.empty_flag),
                                        DATA_W'(i_out_mon.empty_flag));
                    if (i_out_mon.depth_now !== want.depth_now)
                        report_mismatch("depth_now", DATA_W'(want.depth_now),
                                        DATA_W'(i_out_mon.depth_now));
                    if (i_out_mon.found_flag !== want.found_flag)
                        report_mismatch("found_flag", DATA_W'(want.found_flag),
                                        DATA_W'(i_out_mon.found_flag));
                    if (i_out_mon.rejected_flag !== want.rejected_flag)
                        report_mismatch("rejected_flag", DATA_W'(want.rejected_flag),
                                        DATA_W'(i_out_mon.rejected_flag));
                end
            end
        end
        o_pending_count <= status_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// stimulus and verdict for the stack unit
module tb_top import lsd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 400;
    localparam int WINDOW_ITEMS  = 48;
    localparam int MAX_IDLE      = 14;
    localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 200000;

    // opcodes the block leaves unused
    localparam logic [OPC_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_C = 3'd7;

    localparam t_data VAL_MIN    = t_data'(32'h8000_0000);
    localparam t_data VAL_MAX    = t_data'(32'h7fff_ffff);
    localparam t_data REPEAT_KEY = t_data'(32'h0000_0007);
    localparam t_data ABSENT_KEY = t_data'(32'h1234_5678);

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_e;

    logic i_clk;
    logic i_rst_n;
    bit   burst_mode;
    int   fail_count;
    int   pending_count;

    lsd_in_if  in_if ();
    lsd_out_if out_if ();

    lifo_stack_with_value_delete_unit #(.DEPTH(STACK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    lsd_checker #(.DEPTH(STACK_DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_if),
        .i_out_mon       (out_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall before taking each beat
    initial begin
        int stall;
        out_if.ready = 1'b0;
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1 || out_if.ready !== 1'b1);
            @(negedge i_clk);
        end
    end

    // one input beat, with a random gap in front
    task automatic send_beat(input logic [OPC_W-1:0] opc, input t_data val);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.opcode        <= opc;
        in_if.operand_value <= val;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // corner cases: empty stack, full stack, extremes, multi-match delete, spare opcodes
    task automatic run_directed();
        t_data v;
        send_beat(OP_POP, REPEAT_KEY);
        send_beat(OP_DELETE, '0);
        send_beat(OP_SEARCH, '0);
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (i == 1)           v = VAL_MIN;
            else if (i == 2)      v = VAL_MAX;
            else if (i == 4)      v = '1;
            else if (i == 5)      v = '0;
            else if (i % 3 == 0)  v = REPEAT_KEY;
            else                  v = t_data'($urandom);
            send_beat(OP_PUSH, v);
        end
        send_beat(OP_PUSH, ABSENT_KEY);
        send_beat(OP_SEARCH, VAL_MAX);
        send_beat(OP_SEARCH, ABSENT_KEY);
        send_beat(OP_DELETE, REPEAT_KEY);
        send_beat(OP_DELETE, ABSENT_KEY);
        send_beat(OP_POP, '0);
        send_beat(OP_SPARE_A, VAL_MIN);
        send_beat(OP_SPARE_B, VAL_MAX);
        send_beat(OP_SPARE_C, '1);
        send_beat(OP_CLEAR, '0);
    endtask

    // random windows that lean toward filling, draining or a balanced mix
    task automatic run_random();
        op_mix_e          mix;
        int               roll;
        int               push_w, pop_w, search_w, delete_w;
        logic [OPC_W-1:0] opc;
        t_data            v;
        t_data            key_pool [5];
        mix = MIX_BALANCED;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % WINDOW_ITEMS == 0) begin
                mix        = op_mix_e'($urandom_range(0, 2));
                burst_mode = ($urandom_range(0, 3) == 0);
                foreach (key_pool[k]) key_pool[k] = t_data'($urandom);
            end
            case (mix)
                MIX_FILL:  begin push_w = 66; pop_w = 8;  search_w = 10; delete_w = 10; end
                MIX_DRAIN: begin push_w = 12; pop_w = 45; search_w = 13; delete_w = 24; end
                default:   begin push_w = 35; pop_w = 25; search_w = 15; delete_w = 19; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_w)                                    opc = OP_PUSH;
            else if (roll < push_w + pop_w)                       opc = OP_POP;
            else if (roll < push_w + pop_w + search_w)            opc = OP_SEARCH;
            else if (roll < push_w + pop_w + search_w + delete_w) opc = OP_DELETE;
            else if (roll < 96)                                   opc = OP_CLEAR;
            else begin
                case ($urandom_range(0, 2))
                    0:       opc = OP_SPARE_A;
                    1:       opc = OP_SPARE_B;
                    default: opc = OP_SPARE_C;
                endcase
            end
            // a small key pool makes searches hit and deletes remove several entries
            if ($urandom_range(0, 9) < 7) v = key_pool[$urandom_range(0, 4)];
            else                          v = t_data'($urandom);
            send_beat(opc, v);
        end
    endtask

    // reset, stimulus, drain and verdict
    initial begin
        i_rst_n             = 1'b0;
        burst_mode          = 1'b0;
        in_if.valid         = 1'b0;
        in_if.opcode        = OP_PUSH;
        in_if.operand_value = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        run_random();
        in_if.valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lsd_pkg.sv
design/lsd_in_if.sv
design/lsd_out_if.sv
design/lsd_cell.sv
design/lifo_stack_with_value_delete_unit.sv
verif/lsd_checker.sv
verif/tb_top.sv
